// ===== rtl/ckh_pkg.sv =====
// Shared types and constants for the canonical k-mer hasher.
// Used by ckh_ctrl, ckh_datapath and canonical_kmer_hasher_core; no dependencies.
`timescale 1ns / 1ps

package ckh_pkg;

	// MurmurHash3 fmix64 multipliers and shift
	localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
	localparam int unsigned FMIX_SHIFT = 33;

	localparam logic [5:0] KMER_LENGTH_RESET = 6'd31;

	// 2-bit base codes
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CANON,
		ST_MUL_LL,
		ST_MUL_HL,
		ST_MUL_LH,
		ST_ACC_LAST,
		ST_EMIT
	} ckh_state_t;

	typedef struct packed {
		logic shift;       // take the input item into the windows
		logic load_x;      // latch canonical code and first xor-shift
		logic mul_en;      // register one 32x32 partial product
		logic mul_a_hi;    // operand A from upper half of x
		logic mul_b_hi;    // operand B from upper half of the constant
		logic mul_round;   // 0: first multiplier, 1: second multiplier
		logic acc_load;    // accumulator takes the low-by-low product
		logic acc_add;     // add a cross product into the upper half
		logic acc_finish;  // last add, xor-shift back into x
		logic out_load;    // move the result into the output register
	} ckh_cmd_t;

	typedef struct packed {
		logic emit;        // the offered item completes a k-mer
		logic out_free;    // output register can take a result this cycle
	} ckh_status_t;

	// Bit 2 set for a valid base, bits 1:0 the code; case is folded
	function automatic logic [2:0] ckh_base_decode(input logic [7:0] c);
		logic [2:0] r;
		unique case (c)
			8'h41, 8'h61: r = {1'b1, BASE_A};
			8'h43, 8'h63: r = {1'b1, BASE_C};
			8'h47, 8'h67: r = {1'b1, BASE_G};
			8'h54, 8'h74: r = {1'b1, BASE_T};
			default:      r = 3'b000;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/ckh_ctrl.sv =====
// Sequencer for the canonical k-mer hasher: input acceptance, two fmix64
// multiply rounds on the shared multiplier, and hand-off to the output register.
// Depends on ckh_pkg.
`timescale 1ns / 1ps

module ckh_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ckh_pkg::ckh_status_t  status,
	output ckh_pkg::ckh_cmd_t     cmd
);
	import ckh_pkg::*;

	ckh_state_t state_q, state_n;
	logic       round_q, round_n;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= 1'b0;
		end else begin
			state_q <= state_n;
			round_q <= round_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		round_n = round_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && status.emit)
					state_n = ST_CANON;
			end
			ST_CANON: begin
				state_n = ST_MUL_LL;
				round_n = 1'b0;
			end
			ST_MUL_LL:  state_n = ST_MUL_HL;
			ST_MUL_HL:  state_n = ST_MUL_LH;
			ST_MUL_LH:  state_n = ST_ACC_LAST;
			ST_ACC_LAST: begin
				if (!round_q) begin
					round_n = 1'b1;
					state_n = ST_MUL_LL;
				end else begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd           = '0;
		cmd.mul_round = round_q;
		unique case (state_q)
			ST_IDLE:  cmd.shift = accept;
			ST_CANON: cmd.load_x = 1'b1;
			ST_MUL_LL: begin
				cmd.mul_en = 1'b1;
			end
			ST_MUL_HL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_a_hi = 1'b1;
				cmd.acc_load = 1'b1;
			end
			ST_MUL_LH: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_b_hi = 1'b1;
				cmd.acc_add  = 1'b1;
			end
			ST_ACC_LAST: cmd.acc_finish = 1'b1;
			ST_EMIT:     cmd.out_load = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/ckh_datapath.sv =====
// Datapath of the canonical k-mer hasher: rolling windows, run count,
// canonical selection, 32x32 multiplier with accumulator, output register.
// Depends on ckh_pkg.
`timescale 1ns / 1ps

module ckh_datapath #(
	parameter int MAX_KMER = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            base_char,
	input  logic                  first_of_sequence,
	input  logic [5:0]            kmer_length,
	input  ckh_pkg::ckh_cmd_t     cmd,
	output ckh_pkg::ckh_status_t  status,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [63:0]           canonical_code,
	output logic [63:0]           kmer_hash
);
	import ckh_pkg::*;

	localparam int W  = 2 * MAX_KMER;
	localparam int RW = $clog2(MAX_KMER + 1);

	logic [W-1:0]  fwd_q, rc_q;
	logic [RW-1:0] run_q;

	logic [2:0]    dec;
	logic          base_ok;
	logic [1:0]    code;
	logic [W-1:0]  fwd_base, rc_base;
	logic [RW-1:0] run_base, run_inc, run_n;
	logic [5:0]    k_eff;

	assign dec     = ckh_base_decode(base_char);
	assign base_ok = dec[2];
	assign code    = dec[1:0];

	// clamp k to 1..MAX_KMER
	always_comb begin
		if (kmer_length == 6'd0)
			k_eff = 6'd1;
		else if (kmer_length > 6'(MAX_KMER))
			k_eff = 6'(MAX_KMER);
		else
			k_eff = kmer_length;
	end

	assign fwd_base = first_of_sequence ? '0 : fwd_q;
	assign rc_base  = first_of_sequence ? '0 : rc_q;
	assign run_base = first_of_sequence ? '0 : run_q;
	assign run_inc  = (run_base == RW'(MAX_KMER)) ? run_base : run_base + 1'b1;
	assign run_n    = base_ok ? run_inc : '0;

	assign status.emit = base_ok && (6'(run_n) >= k_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rc_q  <= '0;
			run_q <= '0;
		end else if (cmd.shift) begin
			run_q <= run_n;
			if (base_ok) begin
				fwd_q <= (fwd_base << 2) | W'(code);
				rc_q  <= (rc_base >> 2) | (W'(~code) << (W - 2));
			end else begin
				fwd_q <= '0;
				rc_q  <= '0;
			end
		end
	end

	// canonical selection over the last k bases
	logic [6:0]   two_k;
	logic [W-1:0] mask, fwd_m, rc_s, canon_w;
	logic [63:0]  canon;

	assign two_k   = {k_eff, 1'b0};
	assign mask    = ~({W{1'b1}} << two_k);
	assign fwd_m   = fwd_q & mask;
	assign rc_s    = rc_q >> (7'(W) - two_k);
	assign canon_w = (fwd_m < rc_s) ? fwd_m : rc_s;
	assign canon   = 64'(canon_w);

	// fmix64 multiply: low 64 bits from three 32x32 partial products
	logic [63:0] x_q, canon_q, acc_q, prod_s1;
	logic [63:0] mul_c, acc_sum;
	logic [31:0] op_a, op_b;

	assign mul_c   = cmd.mul_round ? FMIX_C2 : FMIX_C1;
	assign op_a    = cmd.mul_a_hi ? x_q[63:32] : x_q[31:0];
	assign op_b    = cmd.mul_b_hi ? mul_c[63:32] : mul_c[31:0];
	assign acc_sum = {acc_q[63:32] + prod_s1[31:0], acc_q[31:0]};

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			canon_q <= canon;
			x_q     <= canon ^ (canon >> FMIX_SHIFT);
		end else if (cmd.acc_finish) begin
			x_q <= acc_sum ^ (acc_sum >> FMIX_SHIFT);
		end
		if (cmd.mul_en)
			prod_s1 <= 64'(op_a) * 64'(op_b);
		if (cmd.acc_load)
			acc_q <= prod_s1;
		else if (cmd.acc_add)
			acc_q <= acc_sum;
	end

	// output register
	logic        out_valid_q;
	logic [63:0] canon_out_q, hash_out_q;

	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			canon_out_q <= canon_q;
			hash_out_q  <= x_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign canonical_code = canon_out_q;
	assign kmer_hash      = hash_out_q;

endmodule

// ===== rtl/canonical_kmer_hasher_core.sv =====
// Canonical k-mer hasher, top level: configuration register, sequencer and datapath.
// Depends on ckh_pkg, ckh_ctrl and ckh_datapath.
`timescale 1ns / 1ps

// Takes one ASCII base per item (ACGT, either case) and keeps rolling forward and
// reverse-complement windows of the last MAX_KMER bases. Each valid base that brings
// the run of valid bases to at least kmer_length yields the smaller of the two codes
// and its MurmurHash3 fmix64. Any other character or first_of_sequence clears the
// window. An item that yields no result is taken without stalling. An item that
// yields a result holds the input while it is taken, the canonical code is selected,
// two fmix64 rounds run on the single shared 32x32 multiplier (three partial
// products and a final accumulate each), and the result moves into the output
// register. While a result waits in the output register, items that yield no
// result are still taken; the next item that yields a result holds the input in
// its last cycle until the output register is free. kmer_length (reset 31, 0 acts
// as 1, values above MAX_KMER act as MAX_KMER) must be written only while idle.
module canonical_kmer_hasher_core #(
	parameter int MAX_KMER = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  base_char,
	input  logic        first_of_sequence,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] canonical_code,
	output logic [63:0] kmer_hash,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	import ckh_pkg::*;

	logic [5:0]  kmer_length_q;
	ckh_cmd_t    cmd;
	ckh_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kmer_length_q <= KMER_LENGTH_RESET;
		else if (cfg_valid && cfg_ready)
			kmer_length_q <= cfg_data;
	end

	ckh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ckh_datapath #(
		.MAX_KMER (MAX_KMER)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.base_char         (base_char),
		.first_of_sequence (first_of_sequence),
		.kmer_length       (kmer_length_q),
		.cmd               (cmd),
		.status            (status),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.canonical_code    (canonical_code),
		.kmer_hash         (kmer_hash)
	);

`ifndef ASSERT_OFF
	a_emit_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && status.emit) |=> cmd.load_x)
		else $error("item completing a k-mer did not start the hash");

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result loaded over an untaken result");

	a_load_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.shift, cmd.load_x, cmd.acc_finish, cmd.out_load, cmd.acc_load}))
		else $error("conflicting datapath commands");
`endif

endmodule
